// ----- rtl/sm3_pkg.sv -----
// SM3 hash core package: round constants, IV and helper functions.
// Used by sm3_ctrl, sm3_datapath and sm3_hash_core; no other dependencies.
package sm3_pkg;

  localparam logic [31:0] TLow  = 32'h79CC4519;
  localparam logic [31:0] THigh = 32'h7A879D8A;
  localparam logic [31:0] PadWord = 32'h80000000;
  localparam logic [3:0]  LenSlot = 4'd14;

  localparam logic [255:0] Iv =
    256'h7380166F4914B2B9172442D7DA8A0600A96F30BC163138AAE38DEE4DB0FB0E4E;

  typedef enum logic [1:0] {
    WSEL_MSG  = 2'd0,
    WSEL_ZERO = 2'd1,
    WSEL_LENH = 2'd2,
    WSEL_LENL = 2'd3
  } wsel_e;

  typedef struct packed {
    logic        push;
    wsel_e       wsel;
    logic        round;
    logic        fold;
    logic        reset_iv;
    logic        out_load;
    logic        out_shift;
    logic        len_add;
    logic [31:0] msg;
    logic [2:0]  cnt;
    logic        fin;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] slot;
    logic       round_done;
  } dp_sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] r);
    logic [63:0] t;
    t = {x, x} << r;
    return t[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

// ----- rtl/sm3_datapath.sv -----
// SM3 datapath: message window, round registers, chaining value, length counter.
// Depends on sm3_pkg.
module sm3_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sm3_pkg::dp_cmd_t  cmd_i,
  output sm3_pkg::dp_sts_t  sts_o,
  output logic [31:0]       out_word_o
);

  logic [31:0] win_q [16];
  logic [31:0] r_q [8];
  logic [31:0] r_nx [8];
  logic [31:0] cv_q [8];
  logic [31:0] ob_q [8];
  logic [63:0] len_q;
  logic [3:0]  slot_q;
  logic [5:0]  j_q;
  logic [2:0]  cnt;
  logic [31:0] mword, pword, wnew, wj, wp, tc, a12, ss1, ss2, ff, gg, tt1, tt2, x;
  logic [3:0]  k;

  always_comb begin
    cnt = (cmd_i.cnt > 3'd4) ? 3'd4 : cmd_i.cnt;
    if (!cmd_i.fin || cnt == 3'd4) begin
      mword = cmd_i.msg;
    end else begin
      mword = (cmd_i.msg & ~(32'hFFFFFFFF >> {cnt, 3'b000}))
            | (sm3_pkg::PadWord >> {cnt, 3'b000});
    end
    unique case (cmd_i.wsel)
      sm3_pkg::WSEL_MSG:  pword = mword;
      sm3_pkg::WSEL_ZERO: pword = 32'd0;
      sm3_pkg::WSEL_LENH: pword = len_q[63:32];
      sm3_pkg::WSEL_LENL: pword = len_q[31:0];
      default:            pword = 32'd0;
    endcase
    k   = j_q[3:0] + 4'd4;
    x   = win_q[k] ^ win_q[k + 4'd7] ^ sm3_pkg::rotl(win_q[k + 4'd13], 5'd15);
    wnew = sm3_pkg::p1(x) ^ sm3_pkg::rotl(win_q[k + 4'd3], 5'd7) ^ win_q[k + 4'd10];
    wj  = win_q[j_q[3:0]];
    wp  = wj ^ ((j_q >= 6'd12) ? wnew : win_q[k]);
    tc  = (j_q < 6'd16) ? sm3_pkg::TLow : sm3_pkg::THigh;
    a12 = sm3_pkg::rotl(r_q[0], 5'd12);
    ss1 = sm3_pkg::rotl(a12 + r_q[4] + sm3_pkg::rotl(tc, j_q[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (j_q < 6'd16) begin
      ff = r_q[0] ^ r_q[1] ^ r_q[2];
      gg = r_q[4] ^ r_q[5] ^ r_q[6];
    end else begin
      ff = (r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]);
      gg = (r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]);
    end
    tt1 = ff + r_q[3] + ss2 + wp;
    tt2 = gg + r_q[7] + ss1 + wj;
    r_nx[0] = tt1;
    r_nx[1] = r_q[0];
    r_nx[2] = sm3_pkg::rotl(r_q[1], 5'd9);
    r_nx[3] = r_q[2];
    r_nx[4] = sm3_pkg::p0(tt2);
    r_nx[5] = r_q[4];
    r_nx[6] = sm3_pkg::rotl(r_q[5], 5'd19);
    r_nx[7] = r_q[6];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      win_q[slot_q] <= pword;
    end else if (cmd_i.round && j_q >= 6'd12) begin
      win_q[k] <= wnew;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        cv_q[i] <= sm3_pkg::Iv[255 - 32*i -: 32];
        r_q[i]  <= 32'd0;
        ob_q[i] <= 32'd0;
      end
      len_q  <= 64'd0;
      slot_q <= 4'd0;
      j_q    <= 6'd0;
    end else begin
      if (cmd_i.len_add) begin
        len_q <= len_q + (cmd_i.fin ? {58'd0, cnt, 3'b000} : 64'd32);
      end
      if (cmd_i.push) begin
        slot_q <= slot_q + 4'd1;
        if (slot_q == 4'd15) begin
          for (int i = 0; i < 8; i++) r_q[i] <= cv_q[i];
        end
      end
      if (cmd_i.round) begin
        j_q <= j_q + 6'd1;
        for (int i = 0; i < 8; i++) r_q[i] <= r_nx[i];
      end
      if (cmd_i.fold) begin
        for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] ^ r_nx[i];
      end
      if (cmd_i.out_load) begin
        for (int i = 0; i < 8; i++) ob_q[i] <= cv_q[i] ^ r_nx[i];
      end else if (cmd_i.out_shift) begin
        for (int i = 0; i < 7; i++) ob_q[i] <= ob_q[i+1];
      end
      if (cmd_i.reset_iv) begin
        for (int i = 0; i < 8; i++) cv_q[i] <= sm3_pkg::Iv[255 - 32*i -: 32];
        len_q  <= 64'd0;
        slot_q <= 4'd0;
      end
    end
  end

  assign sts_o.slot       = slot_q;
  assign sts_o.round_done = (j_q == 6'd63);
  assign out_word_o       = ob_q[0];

endmodule

// ----- rtl/sm3_ctrl.sv -----
// SM3 controller: sequences word intake, padding, rounds and digest output.
// Depends on sm3_pkg.
module sm3_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic [31:0]       msg_word_i,
  input  logic [2:0]        byte_count_i,
  input  logic              final_item_i,
  output logic              valid_o,
  output logic              digest_last_o,
  input  logic              stall_i,
  output sm3_pkg::dp_cmd_t  cmd_o,
  input  sm3_pkg::dp_sts_t  sts_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_ROUND, S_PADW, S_ZERO, S_LENH, S_LENL, S_OUT
  } state_e;

  state_e     state_q;
  state_e     ret_q;
  logic [2:0] oc_q;
  logic       acc;

  assign stall_o = (state_q != S_IDLE);
  assign acc     = valid_i && !stall_o;
  assign valid_o = (state_q == S_OUT);
  assign digest_last_o = (oc_q == 3'd7);

  always_comb begin
    cmd_o = '0;
    cmd_o.msg  = msg_word_i;
    cmd_o.cnt  = byte_count_i;
    cmd_o.fin  = final_item_i;
    cmd_o.wsel = sm3_pkg::WSEL_MSG;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.push    = acc;
        cmd_o.len_add = acc;
      end
      S_ROUND: begin
        cmd_o.round = 1'b1;
        cmd_o.fold  = sts_i.round_done;
      end
      S_PADW: begin
        cmd_o.push = 1'b1;
        cmd_o.fin  = 1'b1;
        cmd_o.cnt  = 3'd0;
      end
      S_ZERO: begin
        cmd_o.push = 1'b1;
        cmd_o.wsel = sm3_pkg::WSEL_ZERO;
      end
      S_LENH: begin
        cmd_o.push = 1'b1;
        cmd_o.wsel = sm3_pkg::WSEL_LENH;
      end
      S_LENL: begin
        cmd_o.push = 1'b1;
        cmd_o.wsel = sm3_pkg::WSEL_LENL;
      end
      S_OUT: begin
        cmd_o.out_shift = !stall_i;
      end
      default: ;
    endcase
    cmd_o.out_load = (state_q == S_ROUND) && sts_i.round_done && (ret_q == S_OUT);
    cmd_o.reset_iv = cmd_o.out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      oc_q    <= 3'd0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            if (final_item_i) begin
              ret_q <= (byte_count_i >= 3'd4) ? S_PADW
                     : (sts_i.slot == sm3_pkg::LenSlot - 4'd1) ? S_LENH : S_ZERO;
            end else begin
              ret_q <= S_IDLE;
            end
            if (sts_i.slot == 4'd15) begin
              state_q <= S_ROUND;
            end else if (final_item_i) begin
              state_q <= (byte_count_i >= 3'd4) ? S_PADW
                       : (sts_i.slot == sm3_pkg::LenSlot - 4'd1) ? S_LENH : S_ZERO;
            end
          end
        end
        S_ROUND: begin
          if (sts_i.round_done) begin
            state_q <= ret_q;
            oc_q    <= 3'd0;
          end
        end
        S_PADW, S_ZERO: begin
          ret_q <= (sts_i.slot == sm3_pkg::LenSlot - 4'd1) ? S_LENH : S_ZERO;
          if (sts_i.slot == 4'd15) begin
            state_q <= S_ROUND;
          end else begin
            state_q <= (sts_i.slot == sm3_pkg::LenSlot - 4'd1) ? S_LENH : S_ZERO;
          end
        end
        S_LENH: begin
          state_q <= S_LENL;
        end
        S_LENL: begin
          ret_q   <= S_OUT;
          state_q <= S_ROUND;
        end
        S_OUT: begin
          if (!stall_i) begin
            oc_q <= oc_q + 3'd1;
            if (oc_q == 3'd7) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/sm3_hash_core.sv -----
// SM3 hash core top level: controller plus datapath.
// Depends on sm3_pkg, sm3_ctrl and sm3_datapath.
//
// Usage: message words enter on the input channel (valid_i/stall_o) as
// big-endian words with byte_count_i valid bytes and final_item_i on the last
// transaction. The core pads the message itself. A word that fills a 16-word
// block starts a compression, one round per cycle from the round registers;
// stall_o is high for that time. After the final transaction the core writes
// the pad word if one is needed, the zero and length words, runs one or two
// compressions, and then presents the eight digest words A..H on the output
// channel (valid_o/stall_i), one per transaction, digest_last_o on the eighth.
// While the receiver stalls the current word holds and no input is taken.
// Reset loads the IV, clears the length counter and returns to idle.
module sm3_hash_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] msg_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        final_item_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] digest_word_o,
  output logic        digest_last_o
);

  sm3_pkg::dp_cmd_t cmd;
  sm3_pkg::dp_sts_t sts;

  sm3_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .stall_o       (stall_o),
    .msg_word_i    (msg_word_i),
    .byte_count_i  (byte_count_i),
    .final_item_i  (final_item_i),
    .valid_o       (valid_o),
    .digest_last_o (digest_last_o),
    .stall_i       (stall_i),
    .cmd_o         (cmd),
    .sts_i         (sts)
  );

  sm3_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (digest_word_o)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> stall_o) else $error("input accepted during digest output");
  a_round_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.round && cmd.push)) else $error("push during compression");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !stall_i && digest_last_o) |=> !valid_o)
    else $error("output continues after last digest word");
`endif

endmodule

// ----- dv/tb_sm3_hash_core.sv -----
// Testbench for sm3_hash_core: drives message transactions, predicts each digest
// with its own SM3 model and compares every digest word. Depends on sm3_hash_core.
module tb_sm3_hash_core;

  localparam logic [255:0] InitVec =
    256'h7380166F4914B2B9172442D7DA8A0600A96F30BC163138AAE38DEE4DB0FB0E4E;
  localparam int unsigned LimitCycles = 1500000;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  count;
    logic        fin;
    logic        has_digest;
    logic [31:0] first_word;
  } stim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [31:0] msg_word_i = '0;
  logic [2:0]  byte_count_i = '0;
  logic        final_item_i = 1'b0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [31:0] digest_word_o;
  logic        digest_last_o;

  logic [31:0] chain_q [8];
  logic [31:0] block_buf [16];
  int unsigned block_fill;
  logic [63:0] msg_bits;
  digest_t     digest_queue [$];
  int unsigned mismatches;
  int unsigned digests_seen;
  int unsigned messages_sent;
  int unsigned cycle_count;
  bit          quiet;
  int unsigned out_gap;
  stim_t       directed [$];

  sm3_hash_core u_dut (
    .clk_i, .rst_ni, .valid_i, .stall_o, .msg_word_i, .byte_count_i, .final_item_i,
    .valid_o, .stall_i, .digest_word_o, .digest_last_o
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [31:0] rot_left(logic [31:0] x, int unsigned r);
    r = r % 32;
    return (r == 0) ? x : ((x << r) | (x >> (32 - r)));
  endfunction

  task automatic compress_block();
    logic [31:0] w [68];
    logic [31:0] a, b, c, d, e, f, g, h, ss1, ss2, tt1, tt2, ff, gg, tc, x;
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
    e = chain_q[4]; f = chain_q[5]; g = chain_q[6]; h = chain_q[7];
    for (int i = 0; i < 16; i++) w[i] = block_buf[i];
    for (int i = 16; i < 68; i++) begin
      x = w[i-16] ^ w[i-9] ^ rot_left(w[i-3], 15);
      w[i] = (x ^ rot_left(x, 15) ^ rot_left(x, 23)) ^ rot_left(w[i-13], 7) ^ w[i-6];
    end
    for (int j = 0; j < 64; j++) begin
      tc = (j < 16) ? 32'h79CC4519 : 32'h7A879D8A;
      ss1 = rot_left(rot_left(a, 12) + e + rot_left(tc, j), 7);
      ss2 = ss1 ^ rot_left(a, 12);
      if (j < 16) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c; c = rot_left(b, 9); b = a; a = tt1;
      h = g; g = rot_left(f, 19); f = e;
      e = tt2 ^ rot_left(tt2, 9) ^ rot_left(tt2, 17);
    end
    chain_q[0] ^= a; chain_q[1] ^= b; chain_q[2] ^= c; chain_q[3] ^= d;
    chain_q[4] ^= e; chain_q[5] ^= f; chain_q[6] ^= g; chain_q[7] ^= h;
  endtask

  task automatic absorb_word(logic [31:0] w);
    block_buf[block_fill] = w;
    block_fill++;
    if (block_fill == 16) begin
      compress_block();
      block_fill = 0;
    end
  endtask

  task automatic reset_hash_state();
    for (int i = 0; i < 8; i++) chain_q[i] = InitVec[255 - 32*i -: 32];
    block_fill = 0;
    msg_bits = '0;
  endtask

  task automatic predict_transaction(logic [31:0] word, logic [2:0] count, logic fin);
    int unsigned n;
    if (!fin) begin
      msg_bits += 64'd32;
      absorb_word(word);
      return;
    end
    n = (count > 4) ? 4 : count;
    msg_bits += 64'(8 * n);
    if (n == 4) begin
      absorb_word(word);
      absorb_word(32'h80000000);
    end else begin
      absorb_word((word & ~(32'hFFFFFFFF >> (8 * n))) | (32'h80000000 >> (8 * n)));
    end
    while (block_fill != 14) absorb_word('0);
    absorb_word(msg_bits[63:32]);
    absorb_word(msg_bits[31:0]);
    for (int i = 0; i < 8; i++) digest_queue.push_back('{chain_q[i], i == 7});
    reset_hash_state();
    messages_sent++;
  endtask

  task automatic send_word(logic [31:0] word, logic [2:0] count, logic fin);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    valid_i <= 1'b1;
    msg_word_i <= word;
    byte_count_i <= count;
    final_item_i <= fin;
    do @(posedge clk_i); while (stall_o);
    predict_transaction(word, count, fin);
    @(negedge clk_i);
  endtask

  task automatic send_message(int unsigned words, logic [2:0] last_count);
    for (int i = 0; i < words; i++) send_word($urandom, 3'd4, 1'b0);
    send_word($urandom, last_count, 1'b1);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
    if (rst_ni && valid_o && !stall_i) begin
      digests_seen++;
      if (digest_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected digest word %h", digest_word_o);
      end else begin
        digest_t exp_d;
        exp_d = digest_queue.pop_front();
        if (exp_d.word !== digest_word_o || exp_d.last !== digest_last_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Digest mismatch: expected %h/%b, got %h/%b",
                     exp_d.word, exp_d.last, digest_word_o, digest_last_o);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (quiet) begin
      stall_i <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      if (out_gap == 0) stall_i <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(1, 19);
      stall_i <= 1'b1;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned words;
    int unsigned wait_cycles;
    mismatches = 0; digests_seen = 0; messages_sent = 0; cycle_count = 0;
    quiet = 1'b0; out_gap = 0;
    reset_hash_state();
    // Empty message: the digest is the published SM3 value of "".
    directed.push_back('{32'h0, 3'd0, 1'b1, 1'b1, 32'h1AB21D83});
    // "abc": the published test vector.
    directed.push_back('{32'h61626300, 3'd3, 1'b1, 1'b1, 32'h66C7F0F4});
    directed.push_back('{32'hFFFFFFFF, 3'd1, 1'b1, 1'b0, '0});
    directed.push_back('{32'hFFFFFFFF, 3'd2, 1'b1, 1'b0, '0});
    directed.push_back('{32'hFFFFFFFF, 3'd4, 1'b1, 1'b0, '0});
    directed.push_back('{32'hFFFFFFFF, 3'd7, 1'b1, 1'b0, '0});
    directed.push_back('{32'hA5A5A5A5, 3'd5, 1'b1, 1'b0, '0});
    directed.push_back('{32'h12345678, 3'd1, 1'b0, 1'b0, '0});
    directed.push_back('{32'h00000000, 3'd6, 1'b1, 1'b0, '0});
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed[k]) begin
      send_word(directed[k].word, directed[k].count, directed[k].fin);
      if (directed[k].has_digest && digest_queue[0].word !== directed[k].first_word) begin
        mismatches++;
        $display("Known answer mismatch: expected %h, predicted %h",
                 directed[k].first_word, digest_queue[0].word);
      end
    end
    // Messages that fill a block exactly or leave room short of the length words.
    send_message(13, 3'd4);
    send_message(14, 3'd0);
    send_message(15, 3'd3);
    send_message(31, 3'd4);
    sent = 0;
    while (sent < 320) begin
      if (sent > 260) quiet = 1'b1;
      words = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 17);
      send_message(words, 3'($urandom_range(0, 7)));
      sent += words + 1;
    end
    valid_i <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk_i);
    wait_cycles = 200;
    repeat (wait_cycles) @(posedge clk_i);
    $display("Hashed %0d messages, including known-answer and padding boundary cases,",
             messages_sent);
    $display("and checked %0d digest words under random stalls on both sides.",
             digests_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
